/* design/crcwf_pkg.sv */
// Shared types, codes and CRC helper for the CRC-8 word framer.
package crcwf_pkg;

    // CRC-8 definition: polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;
    localparam logic [7:0] CrcTop  = 8'h80;

    // Default depth of the job queue between front and back.
    localparam int JobQueueDepth = 2;

    // Input function codes.
    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_RX   = 2'd2;

    // Receive byte position within a group of three.
    localparam logic [1:0] PHASE_HIGH  = 2'd0;
    localparam logic [1:0] PHASE_LOW   = 2'd1;
    localparam logic [1:0] PHASE_CHECK = 2'd2;

    // Result kinds.
    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_RX = 1'b1;

    // Jobs handed from the front to the back.
    typedef enum logic [1:0] {
        JOB_TX_CMD,
        JOB_TX_DATA,
        JOB_RX_WORD
    } t_job_op;

    typedef struct packed {
        t_job_op     op;
        logic [15:0] word;       // Word to send, or the received word.
        logic [7:0]  crc_part;   // CRC register after the high byte (data jobs).
        logic        crc_ok;     // Receive jobs only.
        logic        any_error;  // Receive jobs only.
    } t_job;

    // Runs the CRC register through eight bit steps after a byte was XORed in.
    function automatic logic [7:0] crc8_byte(input logic [7:0] value);
        logic [7:0] crc;
        crc = value;
        for (int i = 0; i < 8; i++) begin
            if ((crc & CrcTop) != 8'h00) begin
                crc = {crc[6:0], 1'b0} ^ CrcPoly;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* design/crcwf_front.sv */
// Front end: accepts input items, tracks the receive grouping and queues jobs.
module crcwf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_func,
    input  logic [15:0]   i_word,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_job_push,
    output crcwf_pkg::t_job o_job
);
    import crcwf_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_high,  n_high;
    logic [7:0] r_low,   n_low;
    logic [7:0] r_part,  n_part;
    logic [7:0] r_crc,   n_crc;
    logic       r_error, n_error;
    logic       accept;
    logic       rx_ok;

    assign accept = i_push && !i_q_full;
    assign rx_ok  = (i_rx_byte == r_crc);

    // Classify the accepted item and update the receive state.
    always_comb begin
        n_phase        = r_phase;
        n_high         = r_high;
        n_low          = r_low;
        n_part         = r_part;
        n_crc          = r_crc;
        n_error        = r_error;
        o_job_push     = 1'b0;
        o_job.op       = JOB_TX_CMD;
        o_job.word     = i_word;
        o_job.crc_part = crc8_byte(CrcInit ^ i_word[15:8]);
        o_job.crc_ok   = 1'b0;
        o_job.any_error = 1'b0;
        if (accept) begin
            case (i_func)
                FUNC_CMD: begin
                    n_phase    = PHASE_HIGH;
                    n_error    = 1'b0;
                    o_job_push = 1'b1;
                    o_job.op   = JOB_TX_CMD;
                end
                FUNC_DATA: begin
                    o_job_push = 1'b1;
                    o_job.op   = JOB_TX_DATA;
                end
                FUNC_RX: begin
                    case (r_phase)
                        PHASE_LOW: begin
                            n_low   = i_rx_byte;
                            n_crc   = crc8_byte(r_part ^ i_rx_byte);
                            n_phase = PHASE_CHECK;
                        end
                        PHASE_CHECK: begin
                            n_error         = r_error || !rx_ok;
                            n_phase         = PHASE_HIGH;
                            o_job_push      = 1'b1;
                            o_job.op        = JOB_RX_WORD;
                            o_job.word      = {r_high, r_low};
                            o_job.crc_ok    = rx_ok;
                            o_job.any_error = r_error || !rx_ok;
                        end
                        default: begin
                            n_high  = i_rx_byte;
                            n_part  = crc8_byte(CrcInit ^ i_rx_byte);
                            n_phase = PHASE_LOW;
                        end
                    endcase
                end
                default: begin
                    // Unused function code: ignored.
                end
            endcase
        end
    end

    // Control state is reset; byte and CRC holders are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_HIGH;
            r_error <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_error <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
        r_part <= n_part;
        r_crc  <= n_crc;
    end

endmodule

/* design/crcwf_jobq.sv */
// Small job queue that lets the front and the back stall independently.
module crcwf_jobq #(
    parameter int Depth = crcwf_pkg::JobQueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  crcwf_pkg::t_job i_job,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output crcwf_pkg::t_job o_job
);
    import crcwf_pkg::*;

    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    t_job              r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CountW-1:0] r_count,  n_count;
    logic              do_wr, do_rd;

    assign o_full  = (r_count == CountW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Pointer wrap and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    // The front never offers a job while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("job pushed into a full queue");

    // Occupancy never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(Depth))
        else $error("job queue occupancy out of range");

    // A lone write grows the occupancy by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_wr && !do_rd |=> r_count == $past(r_count) + 1'b1)
        else $error("job queue count did not follow a write");
`endif

endmodule

/* design/crcwf_back.sv */
// Back end: expands each job into its result bytes or word and holds the result.
module crcwf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  crcwf_pkg::t_job i_job,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_kind,
    output logic [7:0]      o_tx_byte,
    output logic [15:0]     o_rx_word,
    output logic            o_crc_ok,
    output logic            o_any_error,
    output logic            o_last
);
    import crcwf_pkg::*;

    logic [1:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic        r_kind;
    logic [7:0]  r_tx_byte;
    logic [15:0] r_rx_word;
    logic        r_crc_ok;
    logic        r_any_error;
    logic        r_last;
    logic        load;
    logic        res_kind;
    logic [7:0]  res_tx_byte;
    logic [15:0] res_rx_word;
    logic        res_crc_ok;
    logic        res_any_error;
    logic        res_last;

    // The output register takes a new result when empty or being drained.
    assign load      = i_job_valid && (!r_valid || i_pop);
    assign o_job_pop = load && res_last;

    // Result for the current position within the job.
    always_comb begin
        res_kind      = KIND_TX;
        res_tx_byte   = 8'h00;
        res_rx_word   = 16'h0000;
        res_crc_ok    = 1'b0;
        res_any_error = 1'b0;
        res_last      = 1'b0;
        case (i_job.op)
            JOB_TX_CMD: begin
                res_tx_byte = (r_idx == 2'd0) ? i_job.word[15:8] : i_job.word[7:0];
                res_last    = (r_idx != 2'd0);
            end
            JOB_TX_DATA: begin
                if (r_idx == 2'd0) begin
                    res_tx_byte = i_job.word[15:8];
                end else if (r_idx == 2'd1) begin
                    res_tx_byte = i_job.word[7:0];
                end else begin
                    res_tx_byte = crc8_byte(i_job.crc_part ^ i_job.word[7:0]);
                    res_last    = 1'b1;
                end
            end
            JOB_RX_WORD: begin
                res_kind      = KIND_RX;
                res_rx_word   = i_job.word;
                res_crc_ok    = i_job.crc_ok;
                res_any_error = i_job.any_error;
                res_last      = 1'b1;
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    // Position counter and output occupancy.
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (i_pop && r_valid) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_idx   = res_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind      <= res_kind;
            r_tx_byte   <= res_tx_byte;
            r_rx_word   <= res_rx_word;
            r_crc_ok    <= res_crc_ok;
            r_any_error <= res_any_error;
            r_last      <= res_last;
        end
    end

    assign o_empty     = !r_valid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx_byte;
    assign o_rx_word   = r_rx_word;
    assign o_crc_ok    = r_crc_ok;
    assign o_any_error = r_any_error;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    // A job stays in the queue while it is partly expanded.
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> i_job_valid)
        else $error("job left the queue mid-expansion");

    // A received word is always the only result of its item.
    a_rx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_RX |-> r_last)
        else $error("received word result not marked last");

    // No job expands into more than three results.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("result position out of range");
`endif

endmodule

/* design/crc8_word_framer_core.sv */
// Top level of the CRC-8 word framer: front end, job queue and back end.
//
// Frames 16-bit words for a byte-serial sensor link and checks received
// words with CRC-8 (polynomial 0x31, preset 0xFF, MSB first, no final XOR).
// Both sides behave as queues: an item is taken when i_push is high and
// o_full is low, and a result is taken when i_pop is high and o_empty is low.
// The front end accepts one item per cycle while the job queue has room;
// receive bytes that complete no word and unused function codes produce no
// job. The back end delivers one result per cycle through its output
// register while results are drained; a command word expands into two
// results, a data word into three and a received word into one, so the
// sustained rate is set by that result count, and the job queue depth
// (QueueDepth) sets how many items the front end can run ahead.
module crc8_word_framer_core #(
    parameter int QueueDepth = crcwf_pkg::JobQueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_word,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_rx_word,
    output logic        o_crc_ok,
    output logic        o_any_error,
    output logic        o_last
);
    import crcwf_pkg::*;

    logic q_full;
    logic q_valid;
    logic job_push;
    logic job_pop;
    t_job job_in;
    t_job job_out;

    assign o_full = q_full;

    // Item intake and receive grouping.
    crcwf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_func     (i_func),
        .i_word     (i_word),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // Decoupling queue.
    crcwf_jobq #(
        .Depth (QueueDepth)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_job   (job_in),
        .i_rd    (job_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    // Result expansion and output register.
    crcwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_rx_word   (o_rx_word),
        .o_crc_ok    (o_crc_ok),
        .o_any_error (o_any_error),
        .o_last      (o_last)
    );

endmodule
